// ===== design/dpt64_pkg.sv =====
// Package for the deterministic primality test core.
// Holds the base and threshold tables used by the core's sequencer, and the multiplier control struct.
package dpt64_pkg;

    localparam int unsigned DEF_WIDTH  = 64;
    localparam int unsigned BASE_COUNT = 12;
    localparam int unsigned BASE_IDX_W = 4;

    function automatic logic [5:0] base_of(input logic [BASE_IDX_W-1:0] k);
        logic [5:0] b;
        unique case (k)
            4'd0:    b = 6'd2;
            4'd1:    b = 6'd3;
            4'd2:    b = 6'd5;
            4'd3:    b = 6'd7;
            4'd4:    b = 6'd11;
            4'd5:    b = 6'd13;
            4'd6:    b = 6'd17;
            4'd7:    b = 6'd19;
            4'd8:    b = 6'd23;
            4'd9:    b = 6'd29;
            4'd10:   b = 6'd31;
            default: b = 6'd37;
        endcase
        return b;
    endfunction

    // threshold after each base; zero means none
    function automatic logic [63:0] limit_of(input logic [BASE_IDX_W-1:0] k);
        logic [63:0] l;
        unique case (k)
            4'd0:    l = 64'd2047;
            4'd1:    l = 64'd1373653;
            4'd2:    l = 64'd25326001;
            4'd3:    l = 64'd3215031751;
            4'd4:    l = 64'd2152302898747;
            4'd5:    l = 64'd3474749660383;
            4'd6:    l = 64'd341550071728321;
            4'd8:    l = 64'd3825123056546413051;
            default: l = 64'd0;
        endcase
        return l;
    endfunction

    typedef struct packed {
        logic start;
        logic busy;
    } mm_ctrl_t;

endpackage

// ===== design/dpt64_mulmod.sv =====
// Shared modular multiplier: shift-and-add, one bit of b per cycle.
// Depends on dpt64_pkg for the control struct.
module dpt64_mulmod #(
    parameter int unsigned WIDTH = dpt64_pkg::DEF_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [WIDTH-1:0]      a,
    input  logic [WIDTH-1:0]      b,
    input  logic [WIDTH-1:0]      n,
    output dpt64_pkg::mm_ctrl_t   ctrl,
    output logic [WIDTH-1:0]      prod
);
    localparam int unsigned CW = $clog2(WIDTH);

    logic [WIDTH-1:0] acc_reg, acc_next, b_reg, a_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [WIDTH:0]   dbl, dbl_r, sum;

    always_comb begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
        sum   = dbl_r + {1'b0, a_reg};
        if (b_reg[WIDTH-1])
            acc_next = (sum >= {1'b0, n}) ? WIDTH'(sum - {1'b0, n}) : sum[WIDTH-1:0];
        else
            acc_next = dbl_r[WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(WIDTH - 1);
            acc_reg  <= '0;
            a_reg    <= a;
            b_reg    <= b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign prod       = acc_reg;
endmodule

// ===== design/deterministic_primality_test_64_core.sv =====
// Deterministic Miller-Rabin primality test, bases 2..37, one candidate at a time.
// Trivial candidates (below 2 or even) go straight to the output; otherwise each round
// uses up to about 2*WIDTH modular products, up to 12 rounds per candidate, all on the
// single bit-serial modular multiplier.
// Throughput: one item at a time; s_tready is high only while idle.
// Reset: aresetn synchronous, active low, returns the sequencer to idle.
module deterministic_primality_test_64_core #(
    parameter int unsigned WIDTH = dpt64_pkg::DEF_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [WIDTH-1:0] s_tdata,   // [WIDTH-1:0] candidate
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata    // [0] is_prime, rest zero
);
    localparam int unsigned SW = $clog2(WIDTH + 1);
    localparam int unsigned IW = dpt64_pkg::BASE_IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_BASE, S_RED, S_POW, S_MUL, S_SQR, S_CHK, S_LOOP, S_NEXT, S_OUT
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] n_reg, d_reg, e_reg, res_reg, sq_reg, x_reg;
    logic [SW-1:0]    s_reg, i_reg;
    logic [IW-1:0]    k_reg;
    logic             prime_reg, mm_start_reg, wait_reg;
    logic [WIDTH-1:0] mm_a_reg, mm_b_reg, prod;
    dpt64_pkg::mm_ctrl_t mm_ctrl;
    logic [WIDTH-1:0] nm1, base_w;
    logic [63:0]      lim;
    logic             mm_done;

    dpt64_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .aclk(aclk), .aresetn(aresetn), .start(mm_start_reg),
        .a(mm_a_reg), .b(mm_b_reg), .n(n_reg), .ctrl(mm_ctrl), .prod(prod)
    );

    assign nm1     = n_reg - 1'b1;
    assign base_w  = WIDTH'(dpt64_pkg::base_of(k_reg));
    assign lim     = dpt64_pkg::limit_of(k_reg);
    assign mm_done = wait_reg && !mm_ctrl.start && !mm_ctrl.busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mm_start_reg <= 1'b0;
            wait_reg     <= 1'b0;
        end else begin
            mm_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    n_reg <= s_tdata;
                    d_reg <= s_tdata - 1'b1;
                    s_reg <= '0;
                    k_reg <= '0;
                    if (s_tdata < WIDTH'(2) || s_tdata[0] == 1'b0) begin
                        prime_reg <= (s_tdata == WIDTH'(2));
                        state_reg <= S_OUT;
                    end else
                        state_reg <= S_PREP;
                end
                S_PREP: if (!d_reg[0]) begin
                    d_reg <= d_reg >> 1;
                    s_reg <= s_reg + 1'b1;
                end else
                    state_reg <= S_BASE;
                S_BASE: begin
                    // base is below 64 and n may be small: reduce by subtraction
                    sq_reg    <= base_w;
                    res_reg   <= WIDTH'(1);
                    e_reg     <= d_reg;
                    state_reg <= S_RED;
                end
                S_RED: if (sq_reg >= n_reg)
                    sq_reg <= sq_reg - n_reg;
                else
                    state_reg <= S_POW;
                S_POW: begin
                    if (e_reg == '0) begin
                        x_reg     <= res_reg;
                        i_reg     <= SW'(1);
                        state_reg <= S_CHK;
                    end else if (e_reg[0]) begin
                        mm_a_reg <= res_reg; mm_b_reg <= sq_reg;
                        mm_start_reg <= 1'b1; wait_reg <= 1'b1;
                        state_reg <= S_MUL;
                    end else begin
                        e_reg <= e_reg >> 1;
                        if ((e_reg >> 1) != '0) begin
                            mm_a_reg <= sq_reg; mm_b_reg <= sq_reg;
                            mm_start_reg <= 1'b1; wait_reg <= 1'b1;
                            state_reg <= S_SQR;
                        end
                    end
                end
                S_MUL: if (mm_done) begin
                    wait_reg <= 1'b0;
                    res_reg  <= prod;
                    e_reg    <= e_reg >> 1;
                    if ((e_reg >> 1) != '0) begin
                        mm_a_reg <= sq_reg; mm_b_reg <= sq_reg;
                        mm_start_reg <= 1'b1; wait_reg <= 1'b1;
                        state_reg <= S_SQR;
                    end else
                        state_reg <= S_POW;
                end
                S_SQR: if (mm_done) begin
                    wait_reg  <= 1'b0;
                    sq_reg    <= prod;
                    state_reg <= S_POW;
                end
                S_CHK: begin
                    if (x_reg == WIDTH'(1) || x_reg == nm1)
                        state_reg <= S_NEXT;
                    else if (i_reg >= s_reg) begin
                        prime_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        mm_a_reg <= x_reg; mm_b_reg <= x_reg;
                        mm_start_reg <= 1'b1; wait_reg <= 1'b1;
                        state_reg <= S_LOOP;
                    end
                end
                S_LOOP: if (mm_done) begin
                    wait_reg <= 1'b0;
                    x_reg    <= prod;
                    i_reg    <= i_reg + 1'b1;
                    if (prod == nm1)
                        state_reg <= S_NEXT;
                    else if (i_reg + 1'b1 >= s_reg) begin
                        prime_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        mm_a_reg <= prod; mm_b_reg <= prod;
                        mm_start_reg <= 1'b1; wait_reg <= 1'b1;
                    end
                end
                S_NEXT: begin
                    if ((lim != 64'd0 && 64'(n_reg) < lim) ||
                        k_reg == IW'(dpt64_pkg::BASE_COUNT - 1)) begin
                        prime_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_BASE;
                    end
                end
                S_OUT: if (m_tready)
                    state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {7'd0, prime_reg};
endmodule
